[sv/cgsr_pkg.sv]
`default_nettype none

package cgsr_pkg;

  localparam int GRID_SIDE = 256;
  localparam int COORD_W   = $clog2(GRID_SIDE);
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int FUNC_W    = 2;
  localparam int FIELD_W   = 12;
  localparam int RAD_W     = 11;
  localparam int CHAR_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W    = ((COORD_W > FIELD_W) ? COORD_W : FIELD_W) + 2;
  localparam int SQ_W      = 2 * DIFF_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_X_MAX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_CHAR = 2'd2;

  localparam logic [CHAR_W-1:0] X_MAX_RST     = 8'd255;
  localparam logic [CHAR_W-1:0] Y_MAX_RST     = 8'd255;
  localparam logic [CHAR_W-1:0] DRAW_CHAR_RST = 8'd42;
  localparam logic [CHAR_W-1:0] EMPTY_CHAR    = 8'd32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RECT = 2'd0,
    FUNC_CIRC = 2'd1,
    FUNC_READ = 2'd2
  } func_e;

  typedef logic [COORD_W-1:0]       coord_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [SQ_W-1:0]   sq_t;

  typedef struct packed {
    logic [CHAR_W-1:0] x_max;
    logic [CHAR_W-1:0] y_max;
    logic [CHAR_W-1:0] draw_char;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic              outside;
  } res_t;

  function automatic coord_t lim_coord(logic [CHAR_W-1:0] v);
    if (int'(v) > GRID_SIDE - 1) begin
      return coord_t'(GRID_SIDE - 1);
    end
    return coord_t'(v);
  endfunction

endpackage

`default_nettype wire

[sv/cgsr_if.sv]
`default_nettype none

interface cgsr_in_if;
  logic                                valid;
  logic                                ready;
  logic [cgsr_pkg::FUNC_W-1:0]         func;
  logic signed [cgsr_pkg::FIELD_W-1:0] x_a;
  logic signed [cgsr_pkg::FIELD_W-1:0] y_a;
  logic signed [cgsr_pkg::FIELD_W-1:0] x_b;
  logic signed [cgsr_pkg::FIELD_W-1:0] y_b;
  logic [cgsr_pkg::RAD_W-1:0]          radius;

  modport source (output valid, func, x_a, y_a, x_b, y_b, radius, input ready);
  modport sink   (input valid, func, x_a, y_a, x_b, y_b, radius, output ready);
endinterface

interface cgsr_out_if;
  logic                        valid;
  logic                        ready;
  logic [cgsr_pkg::CHAR_W-1:0] cell_char;
  logic                        outside;

  modport source (output valid, cell_char, outside, input ready);
  modport sink   (input valid, cell_char, outside, output ready);
endinterface

interface cgsr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cgsr_pkg::CFG_IDX_W-1:0] index;
  logic [cgsr_pkg::CHAR_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/cgsr_cfg_regs.sv]
`default_nettype none

module cgsr_cfg_regs (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  cgsr_cfg_if.sink      cfg_i,
  output cgsr_pkg::cfg_t cfg_o
);
  import cgsr_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_max     <= X_MAX_RST;
      cfg_q.y_max     <= Y_MAX_RST;
      cfg_q.draw_char <= DRAW_CHAR_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_X_MAX:     cfg_q.x_max     <= cfg_i.data;
        REG_Y_MAX:     cfg_q.y_max     <= cfg_i.data;
        REG_DRAW_CHAR: cfg_q.draw_char <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/cgsr_engine.sv]
`default_nettype none

module cgsr_engine (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  cgsr_in_if.sink        in_i,
  input  cgsr_pkg::cfg_t cfg_i,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output cgsr_pkg::res_t res_o
);
  import cgsr_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SCAN,
    ST_READ,
    ST_RESP
  } state_e;

  state_e state_q;
  addr_t  clr_addr_q;
  logic [1:0] mstep_q;

  logic [FUNC_W-1:0]         func_q;
  logic signed [FIELD_W-1:0] xa_q, ya_q, xb_q, yb_q;
  logic [RAD_W-1:0]          rad_q;
  coord_t xm_q, ym_q;
  coord_t col_q, row_q;
  diff_t  dx_q, dy_q;
  sq_t    sqx0_q, sqx_q, sqy_q, rr_q, rr_lo_q, rr_hi_q;
  logic   res_out_q, res_mem_q;

  logic [CHAR_W-1:0] mem_q [GRID_SIDE*GRID_SIDE];
  logic [CHAR_W-1:0] rdata_q;

  coord_t xm_w, ym_w;
  logic   rd_outside;
  diff_t  col_s, row_s, xa_s, ya_s, xb_s, yb_s, rad_s;
  diff_t  mul_op;
  logic signed [2*DIFF_W-1:0] prod;
  sq_t    sq_dist;
  logic   rect_hit, circ_hit, hit;
  logic   last_col, last_row;
  logic   we;
  addr_t  waddr, raddr;
  logic [CHAR_W-1:0] wdata;

  assign xm_w = lim_coord(cfg_i.x_max);
  assign ym_w = lim_coord(cfg_i.y_max);

  assign rd_outside = in_i.x_a[FIELD_W-1] || in_i.y_a[FIELD_W-1] ||
                      (DIFF_W'(in_i.x_a) > $signed(DIFF_W'(xm_w))) ||
                      (DIFF_W'(in_i.y_a) > $signed(DIFF_W'(ym_w)));

  assign col_s = $signed(DIFF_W'(col_q));
  assign row_s = $signed(DIFF_W'(row_q));
  assign xa_s  = DIFF_W'(xa_q);
  assign ya_s  = DIFF_W'(ya_q);
  assign xb_s  = DIFF_W'(xb_q);
  assign yb_s  = DIFF_W'(yb_q);
  assign rad_s = $signed(DIFF_W'(rad_q));

  // shared squaring unit
  always_comb begin
    case (mstep_q)
      2'd0:    mul_op = dx_q;
      2'd1:    mul_op = dy_q;
      default: mul_op = rad_s;
    endcase
  end
  assign prod = mul_op * mul_op;

  assign rect_hit = ((row_s == yb_s) && (col_s >= xa_s) && (col_s < xb_s)) ||
                    ((row_s == ya_s) && (col_s >= xa_s) && (col_s < xb_s)) ||
                    ((col_s == xb_s) && (row_s >= yb_s) && (row_s <= ya_s)) ||
                    ((col_s == xa_s) && (row_s > yb_s) && (row_s <= ya_s)) ||
                    ((row_s == yb_s) && (row_s == ya_s) && (col_s == xb_s) &&
                     (col_s == xa_s));

  assign sq_dist  = sqx_q + sqy_q;
  assign circ_hit = ((dy_q == '0) && ((dx_q == rad_s) || (dx_q == -rad_s))) ||
                    ((dx_q == '0) && ((dy_q == rad_s) || (dy_q == -rad_s))) ||
                    ((sq_dist > rr_lo_q) && (sq_dist < rr_hi_q));

  assign hit = (func_q == FUNC_RECT) ? rect_hit : circ_hit;

  assign last_col = (col_q == xm_q);
  assign last_row = (row_q == ym_q);

  assign we    = (state_q == ST_CLEAR) || ((state_q == ST_SCAN) && hit);
  assign waddr = (state_q == ST_CLEAR) ? clr_addr_q : {row_q, col_q};
  assign wdata = (state_q == ST_CLEAR) ? '0 : cfg_i.draw_char;
  assign raddr = {ya_q[COORD_W-1:0], xa_q[COORD_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign res_o.cell_char = !res_mem_q        ? '0 :
                           (rdata_q == '0)   ? EMPTY_CHAR : rdata_q;
  assign res_o.outside   = res_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      mstep_q    <= '0;
      res_out_q  <= 1'b0;
      res_mem_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + addr_t'(1);
          if (&clr_addr_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_i.valid) begin
            func_q    <= in_i.func;
            xa_q      <= in_i.x_a;
            ya_q      <= in_i.y_a;
            xb_q      <= in_i.x_b;
            yb_q      <= in_i.y_b;
            rad_q     <= in_i.radius;
            xm_q      <= xm_w;
            ym_q      <= ym_w;
            col_q     <= '0;
            row_q     <= '0;
            dx_q      <= -DIFF_W'(in_i.x_a);
            dy_q      <= -DIFF_W'(in_i.y_a);
            mstep_q   <= '0;
            res_out_q <= 1'b0;
            res_mem_q <= 1'b0;
            case (in_i.func)
              FUNC_RECT: state_q <= ST_SCAN;
              FUNC_CIRC: state_q <= ST_MUL;
              FUNC_READ: begin
                if (rd_outside) begin
                  res_out_q <= 1'b1;
                  state_q   <= ST_RESP;
                end else begin
                  state_q <= ST_READ;
                end
              end
              default: state_q <= ST_RESP;
            endcase
          end
        end
        ST_MUL: begin
          mstep_q <= mstep_q + 2'd1;
          case (mstep_q)
            2'd0: begin
              sqx0_q <= SQ_W'(prod);
              sqx_q  <= SQ_W'(prod);
            end
            2'd1: sqy_q <= SQ_W'(prod);
            2'd2: rr_q  <= SQ_W'(prod);
            default: begin
              rr_lo_q <= rr_q - SQ_W'(rad_s);
              rr_hi_q <= rr_q + SQ_W'(rad_s);
              state_q <= ST_SCAN;
            end
          endcase
        end
        ST_SCAN: begin
          if (last_col) begin
            col_q <= '0;
            dx_q  <= -xa_s;
            sqx_q <= sqx0_q;
            if (last_row) begin
              state_q <= ST_RESP;
            end else begin
              row_q <= row_q + coord_t'(1);
              dy_q  <= dy_q + diff_t'(1);
              sqy_q <= sqy_q + SQ_W'($signed({dy_q, 1'b1}));
            end
          end else begin
            col_q <= col_q + coord_t'(1);
            dx_q  <= dx_q + diff_t'(1);
            sqx_q <= sqx_q + SQ_W'($signed({dx_q, 1'b1}));
          end
        end
        ST_READ: begin
          res_mem_q <= 1'b1;
          state_q   <= ST_RESP;
        end
        ST_RESP: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/char_grid_shape_rasterizer.sv]
`default_nettype none

// Character grid rasterizer. A rectangle or circle transaction walks every cell of the
// grid in use, one cell per cycle through the single frame store write port; a circle
// first passes through a squaring setup. A read inside the grid goes to the frame store,
// a read outside it skips the store. Every transaction returns exactly one result,
// buffered in an output register so the next transaction can start while it waits.
// After reset a clearing pass over all GRID_SIDE*GRID_SIDE cells (65536) zeroes the store;
// no transaction is accepted until it ends. Configuration writes are always taken but
// belong between transactions.
module char_grid_shape_rasterizer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cgsr_cfg_if.sink  cfg_i,
  cgsr_in_if.sink   in_i,
  cgsr_out_if.source out_o
);
  import cgsr_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid, res_ready;

  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_outside_q;

  cgsr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  cgsr_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_char_q    <= res.cell_char;
      out_outside_q <= res.outside;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.cell_char = out_char_q;
  assign out_o.outside   = out_outside_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while a transaction is in progress");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |=> out_o.valid)
    else $error("result lost on the way to the output register");

  a_outside_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.outside |-> out_o.cell_char == '0)
    else $error("outside read carries a character");

endmodule

`default_nettype wire

[tb/sv/char_grid_shape_rasterizer_tb.sv]
`timescale 1ns / 1ps

module char_grid_shape_rasterizer_tb;
  import cgsr_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int MAX_GAP      = 18;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 1000;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_OPS    = 13;

  class grid_scoreboard;
    logic [CHAR_W-1:0] frame [GRID_SIDE*GRID_SIDE];
    logic [CHAR_W-1:0] col_max;
    logic [CHAR_W-1:0] row_max;
    logic [CHAR_W-1:0] ink;
    res_t              expected_cells[$];
    int                errors;

    function new();
      foreach (frame[i]) frame[i] = '0;
      col_max = X_MAX_RST;
      row_max = Y_MAX_RST;
      ink     = DRAW_CHAR_RST;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CHAR_W-1:0] data);
      case (idx)
        REG_X_MAX: begin
          col_max = data;
        end
        REG_Y_MAX: begin
          row_max = data;
        end
        REG_DRAW_CHAR: begin
          ink = data;
        end
        default: begin
        end
      endcase
    endfunction

    function void note_op(logic [FUNC_W-1:0] op, logic signed [FIELD_W-1:0] xa_f,
                          logic signed [FIELD_W-1:0] ya_f, logic signed [FIELD_W-1:0] xb_f,
                          logic signed [FIELD_W-1:0] yb_f, logic [RAD_W-1:0] rad_f);
      int     xa, ya, xb, yb, rad, cmax, rmax, r, c;
      longint dx, dy, d, rr;
      bit     hit;
      res_t   res;
      xa   = xa_f;
      ya   = ya_f;
      xb   = xb_f;
      yb   = yb_f;
      rad  = rad_f;
      cmax = (int'(col_max) > GRID_SIDE - 1) ? GRID_SIDE - 1 : int'(col_max);
      rmax = (int'(row_max) > GRID_SIDE - 1) ? GRID_SIDE - 1 : int'(row_max);
      rr   = longint'(rad) * rad;
      res  = '0;
      if (op == FUNC_RECT || op == FUNC_CIRC) begin
        for (r = 0; r <= rmax; r++) begin
          for (c = 0; c <= cmax; c++) begin
            if (op == FUNC_RECT) begin
              hit = (r == yb && c >= xa && c < xb) || (r == ya && c >= xa && c < xb) ||
                    (c == xb && r >= yb && r <= ya) || (c == xa && r > yb && r <= ya) ||
                    (r == ya && r == yb && c == xa && c == xb);
            end else begin
              dx  = c - xa;
              dy  = r - ya;
              d   = dx * dx + dy * dy;
              hit = (r == ya && (c == xa - rad || c == xa + rad)) ||
                    (c == xa && (r == ya - rad || r == ya + rad)) ||
                    (rr - rad < d && d < rr + rad);
            end
            if (hit) begin
              frame[r * GRID_SIDE + c] = ink;
            end
          end
        end
      end else if (op == FUNC_READ) begin
        if (xa < 0 || ya < 0 || xa > cmax || ya > rmax) begin
          res.outside = 1'b1;
        end else if (frame[ya * GRID_SIDE + xa] == '0) begin
          res.cell_char = EMPTY_CHAR;
        end else begin
          res.cell_char = frame[ya * GRID_SIDE + xa];
        end
      end
      expected_cells.push_back(res);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [CHAR_W-1:0] cell_char, logic outside);
      res_t want;
      if (expected_cells.size() == 0) begin
        report($sformatf("unexpected result cell_char=%0d outside=%0b", cell_char, outside));
        return;
      end
      want = expected_cells.pop_front();
      if (cell_char !== want.cell_char) begin
        report($sformatf("cell_char got %0d want %0d", cell_char, want.cell_char));
      end
      if (outside !== want.outside) begin
        report($sformatf("outside got %0b want %0b", outside, want.outside));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cgsr_cfg_if cfg_if ();
  cgsr_in_if  in_if ();
  cgsr_out_if out_if ();

  grid_scoreboard sb;
  bit src_gaps;
  bit snk_gaps;
  int hold_cycles;

  char_grid_shape_rasterizer uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  function automatic int any_coord();
    return int'($urandom_range(0, (1 << FIELD_W) - 1)) - (1 << (FIELD_W - 1));
  endfunction

  task automatic send_op(input logic [FUNC_W-1:0] op, input int xa, input int ya,
                         input int xb, input int yb, input int rad);
    int gap;
    gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.func   <= op;
    in_if.x_a    <= xa[FIELD_W-1:0];
    in_if.y_a    <= ya[FIELD_W-1:0];
    in_if.x_b    <= xb[FIELD_W-1:0];
    in_if.y_b    <= yb[FIELD_W-1:0];
    in_if.radius <= rad[RAD_W-1:0];
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_op(in_if.func, in_if.x_a, in_if.y_a, in_if.x_b, in_if.y_b, in_if.radius);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_cells.size() > 0) @(posedge clk_i);
  endtask

  task automatic set_grid(input int xm, input int ym, input int ch);
    logic [CFG_IDX_W-1:0] idx [3];
    int                   val [3];
    idx = '{REG_X_MAX, REG_Y_MAX, REG_DRAW_CHAR};
    val = '{xm, ym, ch};
    for (int i = 0; i < 3; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i][CHAR_W-1:0];
      do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
      sb.set_reg(cfg_if.index, cfg_if.data);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_op(input int xm, input int ym);
    int                pick, xa, ya, xb, yb, rad, t;
    logic [FUNC_W-1:0] op;
    pick = $urandom_range(0, 99);
    xa   = int'($urandom_range(0, xm + 6)) - 3;
    ya   = int'($urandom_range(0, ym + 6)) - 3;
    xb   = int'($urandom_range(0, xm + 6)) - 3;
    yb   = int'($urandom_range(0, ym + 6)) - 3;
    rad  = $urandom_range(0, ((xm > ym) ? xm : ym) / 2 + 3);
    if (pick < 20) begin
      op = FUNC_RECT;
    end else if (pick < 35) begin
      op = FUNC_CIRC;
    end else if (pick < 95) begin
      op = FUNC_READ;
    end else begin
      op = FUNC_NONE;
    end
    // mostly well-ordered corners, the rest as drawn
    if (op == FUNC_RECT && $urandom_range(0, 4) != 0) begin
      if (xa > xb) begin
        t  = xa;
        xa = xb;
        xb = t;
      end
      if (yb > ya) begin
        t  = ya;
        ya = yb;
        yb = t;
      end
    end
    if (op == FUNC_READ && $urandom_range(0, 3) != 0) begin
      xa = $urandom_range(0, xm);
      ya = $urandom_range(0, ym);
    end
    if ($urandom_range(0, 9) == 0) begin
      xa  = any_coord();
      ya  = any_coord();
      xb  = any_coord();
      yb  = any_coord();
      rad = $urandom_range(0, (1 << RAD_W) - 1);
    end
    send_op(op, xa, ya, xb, yb, rad);
  endtask

  initial begin
    int gap;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      gap = snk_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      sb.check_result(out_if.cell_char, out_if.outside);
    end
  end

  initial begin
    int xm, ym;
    sb = new();
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.func   <= FUNC_RECT;
    in_if.x_a    <= '0;
    in_if.y_a    <= '0;
    in_if.x_b    <= '0;
    in_if.y_b    <= '0;
    in_if.radius <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_X_MAX;
    cfg_if.data  <= '0;
    src_gaps     = 1'b1;
    snk_gaps     = 1'b1;
    hold_cycles  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full grid at reset settings
    send_op(FUNC_READ, 0, 0, 0, 0, 0);
    send_op(FUNC_READ, 255, 255, 0, 0, 0);
    send_op(FUNC_READ, -1, 0, 0, 0, 0);
    send_op(FUNC_READ, 0, -2048, 0, 0, 0);
    send_op(FUNC_READ, 2047, 255, 0, 0, 0);
    send_op(FUNC_RECT, 10, 200, 240, 20, 0);
    send_op(FUNC_READ, 240, 20, 0, 0, 0);
    send_op(FUNC_READ, 10, 20, 0, 0, 0);
    send_op(FUNC_READ, 11, 21, 0, 0, 0);
    send_op(FUNC_CIRC, 128, 128, 0, 0, 100);
    send_op(FUNC_READ, 28, 128, 0, 0, 0);
    send_op(FUNC_NONE, -2048, 2047, -2048, 2047, 2047);
    drain();

    // single-cell rectangle, swapped corners, zero radius, clipped ring
    set_grid(7, 5, 255);
    send_op(FUNC_RECT, 3, 2, 3, 2, 0);
    send_op(FUNC_RECT, 6, 1, 2, 4, 0);
    send_op(FUNC_CIRC, 0, 0, 0, 0, 0);
    send_op(FUNC_CIRC, 3, 2, 0, 0, 3);
    send_op(FUNC_READ, 3, 2, 0, 0, 0);
    send_op(FUNC_READ, 8, 0, 0, 0, 0);
    send_op(FUNC_READ, 0, 6, 0, 0, 0);
    drain();

    // zero draw code reads back as empty
    set_grid(0, 0, 0);
    send_op(FUNC_RECT, 0, 0, 0, 0, 0);
    send_op(FUNC_READ, 0, 0, 0, 0, 0);
    send_op(FUNC_READ, 1, 0, 0, 0, 0);
    drain();

    set_grid(255, 0, 1);
    send_op(FUNC_RECT, 0, 0, 255, 0, 0);
    send_op(FUNC_READ, 255, 0, 0, 0, 0);
    send_op(FUNC_READ, 0, 1, 0, 0, 0);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        1: begin
          xm = 255;
          ym = 0;
        end
        3: begin
          xm = 0;
          ym = 255;
        end
        default: begin
          xm = $urandom_range(1, 23);
          ym = $urandom_range(1, 23);
        end
      endcase
      set_grid(xm, ym, $urandom_range(0, 255));
      src_gaps = ($urandom_range(0, 3) != 0);
      snk_gaps = ($urandom_range(0, 3) != 0);
      // receiver stalls for a long stretch while items keep coming
      if (p == 2) begin
        src_gaps    = 1'b0;
        hold_cycles = LONG_HOLD;
      end
      repeat (PHASE_OPS) random_op(xm, ym);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS char_grid_shape_rasterizer");
    end else begin
      $display("FAIL char_grid_shape_rasterizer");
    end
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("FAIL char_grid_shape_rasterizer");
    $finish;
  end

endmodule
